// File: rtl/wli_pkg.sv
// Shared constants, codes and types for the waypoint line interpolator.
// No dependencies; every other file depends on this package.
package wli_pkg;

   localparam int CB   = 32;             // coordinate bits, signed Q.16
   localparam int WW   = 32;             // port word width
   localparam int DW   = CB + 1;         // magnitude of a coordinate difference
   localparam int SW   = 2 * DW;         // sum of squares
   localparam int RW   = DW;             // square root width
   localparam int NW   = SW - 1;         // dividend width for the step division
   localparam int QW   = RW + 1;         // quotient width kept
   localparam int PLW  = 32;             // point counter
   localparam int CNTW = $clog2(NW + 1); // iteration counter

   localparam logic [WW-1:0] RST_STEP  = WW'(2731);
   localparam logic [WW-1:0] RST_SPEED = WW'(32768);

   localparam int CSR_IW = 1;
   localparam logic [CSR_IW-1:0] CSR_STEP  = 1'd0;
   localparam logic [CSR_IW-1:0] CSR_SPEED = 1'd1;

   localparam logic [1:0] KIND_ACC  = 2'd0;
   localparam logic [1:0] KIND_REJ  = 2'd1;
   localparam logic [1:0] KIND_PT   = 2'd2;
   localparam logic [1:0] KIND_NOPT = 2'd3;

   localparam int OPW = 4;
   typedef logic [OPW-1:0] op_type;
   localparam op_type OP_NONE    = 4'd0;
   localparam op_type OP_LATCH   = 4'd1;
   localparam op_type OP_DECIDE  = 4'd2;
   localparam op_type OP_SQX     = 4'd3;
   localparam op_type OP_SQY     = 4'd4;
   localparam op_type OP_SUM     = 4'd5;
   localparam op_type OP_SQRT    = 4'd6;
   localparam op_type OP_DIVC_LD = 4'd7;
   localparam op_type OP_DIV     = 4'd8;
   localparam op_type OP_TAKEC   = 4'd9;
   localparam op_type OP_MULX    = 4'd10;
   localparam op_type OP_DIV_LD  = 4'd11;
   localparam op_type OP_TAKEX   = 4'd12;
   localparam op_type OP_MULY    = 4'd13;
   localparam op_type OP_TAKEY   = 4'd14;
   localparam op_type OP_EMIT    = 4'd15;

   typedef struct packed {
      op_type op;
   } wli_cmd_type;

   typedef struct packed {
      logic need_seg;   // latched waypoint opens a segment
      logic seg_zero;   // zero length or zero step length
      logic iter_last;  // final iteration of sqrt or divide
      logic out_free;   // output register can take a word
   } wli_stat_type;

endpackage

// File: rtl/wli_if.sv
// Handshake channel interfaces: request, response and register write.
// Depends on wli_pkg for widths.
interface wli_req_if;
   logic                    valid;
   logic                    ready;
   logic                    cmd;
   logic [wli_pkg::WW-1:0]  wp_x;
   logic [wli_pkg::WW-1:0]  wp_y;
   modport source (output valid, cmd, wp_x, wp_y, input ready);
   modport sink   (input valid, cmd, wp_x, wp_y, output ready);
endinterface

interface wli_rsp_if;
   logic                    valid;
   logic                    ready;
   logic [1:0]              kind;
   logic [wli_pkg::WW-1:0]  pt_x;
   logic [wli_pkg::WW-1:0]  pt_y;
   logic [wli_pkg::WW-1:0]  pt_speed;
   logic                    seg_last;
   modport source (output valid, kind, pt_x, pt_y, pt_speed, seg_last, input ready);
   modport sink   (input valid, kind, pt_x, pt_y, pt_speed, seg_last, output ready);
endinterface

interface wli_csr_if;
   logic                        valid;
   logic                        ready;
   logic [wli_pkg::CSR_IW-1:0]  idx;
   logic [wli_pkg::WW-1:0]      wdata;
   modport source (output valid, idx, wdata, input ready);
   modport sink   (input valid, idx, wdata, output ready);
endinterface

// File: rtl/waypoint_line_interpolator.sv
// Top level of the waypoint line interpolator: sequencer plus datapath.
// Depends on wli_pkg, wli_if, wli_ctrl and wli_dp.
//
//   channel   | dir | words
//   req_chan  | in  | cmd, wp_x, wp_y
//   rsp_chan  | out | kind, pt_x, pt_y, pt_speed, seg_last
//   csr_chan  | in  | idx (0 step_length, 1 speed_report), wdata
//
// Point requests and waypoints that open no segment pass decide and emit,
// then ready returns. A waypoint that opens a segment also runs a 33-step
// square root and, unless length or step length is zero, three divides (33
// and 2 x 65 steps) on one bit-serial divider. One item is in work at a time;
// emit waits while the output register holds a word not yet taken. Reset is
// synchronous; it restores both registers, clears prev, position and count.
module waypoint_line_interpolator (
   input  logic      clock,
   input  logic      reset,
   wli_req_if.sink   req_chan,
   wli_rsp_if.source rsp_chan,
   wli_csr_if.sink   csr_chan
);
   import wli_pkg::*;

   wli_cmd_type  cmd;
   wli_stat_type stat;
   logic         req_ready;

   assign req_chan.ready = req_ready;

   wli_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   wli_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_cmd  (req_chan.cmd),
      .req_wp_x (req_chan.wp_x),
      .req_wp_y (req_chan.wp_y),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan),
      .cmd      (cmd),
      .stat     (stat)
   );

endmodule

// File: rtl/wli_ctrl.sv
// Sequencer for the interpolator: walks set-up, sqrt and divide phases.
// Depends on wli_pkg; drives the datapath through wli_cmd_type.
module wli_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  wli_pkg::wli_stat_type stat,
   output wli_pkg::wli_cmd_type  cmd
);
   import wli_pkg::*;

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_DECIDE  = 5'd1;
   localparam logic [4:0] S_SQX     = 5'd2;
   localparam logic [4:0] S_SQY     = 5'd3;
   localparam logic [4:0] S_SUM     = 5'd4;
   localparam logic [4:0] S_SQRT    = 5'd5;
   localparam logic [4:0] S_DIVC_LD = 5'd6;
   localparam logic [4:0] S_DIVC    = 5'd7;
   localparam logic [4:0] S_TAKEC   = 5'd8;
   localparam logic [4:0] S_MULX    = 5'd9;
   localparam logic [4:0] S_DIVX_LD = 5'd10;
   localparam logic [4:0] S_DIVX    = 5'd11;
   localparam logic [4:0] S_TAKEX   = 5'd12;
   localparam logic [4:0] S_MULY    = 5'd13;
   localparam logic [4:0] S_DIVY_LD = 5'd14;
   localparam logic [4:0] S_DIVY    = 5'd15;
   localparam logic [4:0] S_TAKEY   = 5'd16;
   localparam logic [4:0] S_EMIT    = 5'd17;

   logic [4:0] state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LATCH;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            cmd.op   = OP_DECIDE;
            state_in = stat.need_seg ? S_SQX : S_EMIT;
         end
         S_SQX: begin
            cmd.op   = OP_SQX;
            state_in = S_SQY;
         end
         S_SQY: begin
            cmd.op   = OP_SQY;
            state_in = S_SUM;
         end
         S_SUM: begin
            cmd.op   = OP_SUM;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            cmd.op = OP_SQRT;
            if (stat.iter_last) state_in = S_DIVC_LD;
         end
         S_DIVC_LD: begin
            // drop the divisions for a zero length or a zero step length
            if (stat.seg_zero) begin
               state_in = S_EMIT;
            end else begin
               cmd.op   = OP_DIVC_LD;
               state_in = S_DIVC;
            end
         end
         S_DIVC: begin
            cmd.op = OP_DIV;
            if (stat.iter_last) state_in = S_TAKEC;
         end
         S_TAKEC: begin
            cmd.op   = OP_TAKEC;
            state_in = S_MULX;
         end
         S_MULX: begin
            cmd.op   = OP_MULX;
            state_in = S_DIVX_LD;
         end
         S_DIVX_LD: begin
            cmd.op   = OP_DIV_LD;
            state_in = S_DIVX;
         end
         S_DIVX: begin
            cmd.op = OP_DIV;
            if (stat.iter_last) state_in = S_TAKEX;
         end
         S_TAKEX: begin
            cmd.op   = OP_TAKEX;
            state_in = S_MULY;
         end
         S_MULY: begin
            cmd.op   = OP_MULY;
            state_in = S_DIVY_LD;
         end
         S_DIVY_LD: begin
            cmd.op   = OP_DIV_LD;
            state_in = S_DIVY;
         end
         S_DIVY: begin
            cmd.op = OP_DIV;
            if (stat.iter_last) state_in = S_TAKEY;
         end
         S_TAKEY: begin
            cmd.op   = OP_TAKEY;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.op   = OP_EMIT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_iter_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SQRT && !stat.iter_last) |=> (state_ff == S_SQRT))
      else $error("sqrt phase left early");
   a_emit_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_EMIT) |=> (state_ff == S_IDLE))
      else $error("emit did not return to idle");
   a_latch_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_LATCH) |-> (state_ff == S_IDLE && req_valid))
      else $error("item latched outside idle");

endmodule

// File: rtl/wli_dp.sv
// Datapath: segment state, shared multiplier, bit-serial sqrt and divider,
// register file and output register. Depends on wli_pkg and wli_if.
module wli_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_cmd,
   input  logic [wli_pkg::WW-1:0] req_wp_x,
   input  logic [wli_pkg::WW-1:0] req_wp_y,
   wli_rsp_if.source             rsp_chan,
   wli_csr_if.sink               csr_chan,
   input  wli_pkg::wli_cmd_type  cmd,
   output wli_pkg::wli_stat_type stat
);
   import wli_pkg::*;

   logic [WW-1:0]   sl_ff, speed_ff;
   logic            cmd_ff, have_prev_ff;
   logic [CB-1:0]   wpx_ff, wpy_ff, prevx_ff, prevy_ff;
   logic [CB-1:0]   curx_ff, cury_ff, stepx_ff, stepy_ff;
   logic [PLW-1:0]  pl_ff;
   logic [1:0]      kind_ff;
   logic [DW-1:0]   ax_ff, ay_ff;
   logic            sx_ff, sy_ff;
   logic [SW-1:0]   prod_ff, acc_ff, rad_ff;
   logic [RW+1:0]   sqrem_ff;
   logic [RW-1:0]   root_ff, den_ff, dvrem_ff;
   logic [NW-1:0]   num_ff;
   logic [QW-1:0]   q_ff;
   logic [CNTW-1:0] cnt_ff;

   logic            rsp_valid_ff, last_ff;
   logic [1:0]      rkind_ff;
   logic [WW-1:0]   rx_ff, ry_ff, rspeed_ff;

   logic [CB:0]     dx, dy;
   logic [DW-1:0]   mul_a, mul_b;
   logic [RW+3:0]   sq_r2, sq_trial, sq_diff;
   logic            sq_ge;
   logic [RW:0]     dv_r2, dv_sub;
   logic            dv_ge, rnd;
   logic [QW-1:0]   qr;
   logic [CB-1:0]   qmag;
   logic [1:0]      kind_nx;
   logic            emit_pt;

   assign dx = {wpx_ff[CB-1], wpx_ff} - {prevx_ff[CB-1], prevx_ff};
   assign dy = {wpy_ff[CB-1], wpy_ff} - {prevy_ff[CB-1], prevy_ff};

   always_comb begin
      case (cmd.op)
         OP_SQX:  begin mul_a = ax_ff;      mul_b = ax_ff; end
         OP_SQY:  begin mul_a = ay_ff;      mul_b = ay_ff; end
         OP_MULX: begin mul_a = DW'(sl_ff); mul_b = ax_ff; end
         OP_MULY: begin mul_a = DW'(sl_ff); mul_b = ay_ff; end
         default: begin mul_a = '0;         mul_b = '0;    end
      endcase
   end

   // restoring square root, one result bit per cycle
   assign sq_r2    = {sqrem_ff, rad_ff[SW-1:SW-2]};
   assign sq_trial = {2'b00, root_ff, 2'b01};
   assign sq_ge    = (sq_r2 >= sq_trial);
   assign sq_diff  = sq_r2 - sq_trial;

   // restoring division, one quotient bit per cycle
   assign dv_r2  = {dvrem_ff, num_ff[NW-1]};
   assign dv_sub = dv_r2 - {1'b0, den_ff};
   assign dv_ge  = (dv_r2 >= {1'b0, den_ff});

   // round half away from zero on the magnitude
   assign rnd  = ({dvrem_ff, 1'b0} >= {1'b0, den_ff});
   assign qr   = q_ff + QW'(rnd);
   assign qmag = qr[CB-1:0];

   always_comb begin
      if (cmd_ff) kind_nx = (pl_ff == '0) ? KIND_NOPT : KIND_PT;
      else        kind_nx = (pl_ff != '0) ? KIND_REJ : KIND_ACC;
   end

   assign emit_pt = (kind_ff == KIND_PT);

   assign stat.need_seg  = !cmd_ff && (pl_ff == '0) && have_prev_ff;
   assign stat.seg_zero  = (root_ff == '0) || (sl_ff == '0);
   assign stat.iter_last = (cnt_ff == CNTW'(1));
   assign stat.out_free  = !rsp_valid_ff || rsp_chan.ready;

   assign csr_chan.ready    = 1'b1;
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.kind     = rkind_ff;
   assign rsp_chan.pt_x     = rx_ff;
   assign rsp_chan.pt_y     = ry_ff;
   assign rsp_chan.pt_speed = rspeed_ff;
   assign rsp_chan.seg_last = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sl_ff        <= RST_STEP;
         speed_ff     <= RST_SPEED;
         have_prev_ff <= 1'b0;
         prevx_ff     <= '0;
         prevy_ff     <= '0;
         curx_ff      <= '0;
         cury_ff      <= '0;
         stepx_ff     <= '0;
         stepy_ff     <= '0;
         pl_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         if (csr_chan.valid) begin
            case (csr_chan.idx)
               CSR_STEP:  sl_ff    <= csr_chan.wdata;
               CSR_SPEED: speed_ff <= csr_chan.wdata;
               default:   ;
            endcase
         end
         if (rsp_chan.ready && cmd.op != OP_EMIT) rsp_valid_ff <= 1'b0;

         case (cmd.op)
            OP_LATCH: begin
               cmd_ff <= req_cmd;
               wpx_ff <= req_wp_x[CB-1:0];
               wpy_ff <= req_wp_y[CB-1:0];
            end
            OP_DECIDE: begin
               kind_ff <= kind_nx;
               if (stat.need_seg) begin
                  ax_ff    <= dx[CB] ? DW'(-dx) : DW'(dx);
                  ay_ff    <= dy[CB] ? DW'(-dy) : DW'(dy);
                  sx_ff    <= dx[CB];
                  sy_ff    <= dy[CB];
                  curx_ff  <= prevx_ff;
                  cury_ff  <= prevy_ff;
                  stepx_ff <= '0;
                  stepy_ff <= '0;
               end
            end
            OP_SQX, OP_MULX, OP_MULY: prod_ff <= mul_a * mul_b;
            OP_SQY: begin
               acc_ff  <= prod_ff;
               prod_ff <= mul_a * mul_b;
            end
            OP_SUM: begin
               rad_ff   <= acc_ff + prod_ff;
               sqrem_ff <= '0;
               root_ff  <= '0;
               cnt_ff   <= CNTW'(RW);
            end
            OP_SQRT: begin
               rad_ff   <= {rad_ff[SW-3:0], 2'b00};
               sqrem_ff <= sq_ge ? sq_diff[RW+1:0] : sq_r2[RW+1:0];
               root_ff  <= {root_ff[RW-2:0], sq_ge};
               cnt_ff   <= cnt_ff - CNTW'(1);
            end
            OP_DIVC_LD: begin
               num_ff   <= {root_ff, {(NW-RW){1'b0}}};
               den_ff   <= RW'(sl_ff);
               dvrem_ff <= '0;
               q_ff     <= '0;
               cnt_ff   <= CNTW'(RW);
            end
            OP_DIV_LD: begin
               num_ff   <= prod_ff[NW-1:0];
               den_ff   <= root_ff;
               dvrem_ff <= '0;
               q_ff     <= '0;
               cnt_ff   <= CNTW'(NW);
            end
            OP_DIV: begin
               num_ff   <= {num_ff[NW-2:0], 1'b0};
               dvrem_ff <= dv_ge ? dv_sub[RW-1:0] : dv_r2[RW-1:0];
               q_ff     <= {q_ff[QW-2:0], dv_ge};
               cnt_ff   <= cnt_ff - CNTW'(1);
            end
            OP_TAKEC: pl_ff <= (|q_ff[QW-1:PLW]) ? '1 : q_ff[PLW-1:0];
            OP_TAKEX: stepx_ff <= sx_ff ? -qmag : qmag;
            OP_TAKEY: stepy_ff <= sy_ff ? -qmag : qmag;
            OP_EMIT: begin
               rsp_valid_ff <= 1'b1;
               rkind_ff     <= kind_ff;
               rx_ff        <= emit_pt ? WW'($signed(curx_ff)) : '0;
               ry_ff        <= emit_pt ? WW'($signed(cury_ff)) : '0;
               rspeed_ff    <= emit_pt ? speed_ff : '0;
               last_ff      <= emit_pt && (pl_ff == PLW'(1));
               case (kind_ff)
                  KIND_PT: begin
                     curx_ff <= curx_ff + stepx_ff;
                     cury_ff <= cury_ff + stepy_ff;
                     pl_ff   <= pl_ff - PLW'(1);
                  end
                  KIND_ACC: begin
                     prevx_ff     <= wpx_ff;
                     prevy_ff     <= wpy_ff;
                     have_prev_ff <= 1'b1;
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      end
   end

   a_pt_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_EMIT && kind_ff == KIND_PT) |-> (pl_ff != '0))
      else $error("point emitted with no points left");
   a_pt_dec: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_EMIT && kind_ff == KIND_PT) |=> (pl_ff == $past(pl_ff) - PLW'(1)))
      else $error("point counter not advanced");
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.op == OP_EMIT))
      else $error("response word without emit");
   a_busy_reject: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_DECIDE && !cmd_ff && pl_ff != '0) |=> (kind_ff == KIND_REJ))
      else $error("busy waypoint not rejected");

endmodule
